@@ rtl/core/hrd_pkg.sv @@
// ----------------------------------------------------------------------------
// hrd_pkg
// Shared constants for the HTTP response deframer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hrd_pkg;

    // width of content-length values, chunk sizes and the body counter
    localparam int LenBits = 32;

    // request codes on s_req_type
    localparam logic [1:0] REQ_BYTE    = 2'd0;
    localparam logic [1:0] REQ_CLOSE   = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // codes on m_phase
    localparam logic [1:0] OUT_BUSY  = 2'd0;
    localparam logic [1:0] OUT_DONE  = 2'd1;
    localparam logic [1:0] OUT_ERROR = 2'd2;

    // codes on m_error_kind
    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_NO_HTTP   = 4'd1;
    localparam logic [3:0] ERR_NO_SPACE  = 4'd2;
    localparam logic [3:0] ERR_VERSION   = 4'd3;
    localparam logic [3:0] ERR_CODE      = 4'd4;
    localparam logic [3:0] ERR_NO_COLON  = 4'd5;
    localparam logic [3:0] ERR_EMPTY_HDR = 4'd6;
    localparam logic [3:0] ERR_LENGTH    = 4'd7;
    localparam logic [3:0] ERR_CSIZE     = 4'd8;
    localparam logic [3:0] ERR_CEND      = 4'd9;
    localparam logic [3:0] ERR_OVERFLOW  = 4'd10;

endpackage

`default_nettype wire

@@ rtl/core/http_response_deframer.sv @@
// ----------------------------------------------------------------------------
// http_response_deframer
// Parses an HTTP/1.x response byte stream and passes out its body bytes.
// ----------------------------------------------------------------------------
// Input channel (s_*): one beat per request. s_req_type selects a response
// byte (s_data_byte), a peer close, or a restart for a new response.
// Output channel (m_*): exactly one result beat per input beat, in order. It
// carries body_valid/body_byte for payload bytes plus the running status:
// phase, error_kind, status code, version and the framing flags.
// Results are registered: a beat's result is on m_* in the cycle after it is accepted.
// Throughput: one beat per cycle while m_ready is high; the whole per-byte
// parse step (matching, one x10 or x16 accumulate and compare) sits between
// the state registers and the result register.
// Reset (aresetn low, synchronous) puts the parser at the start of a status
// line and drops m_valid. A restart request resets the parser the same way in-band.
// When the receiver stalls, the result register holds and s_ready stays high
// only if the held beat is being taken in the same cycle.
// After completion or an error, bytes and closes are ignored until restart.
// ----------------------------------------------------------------------------
`default_nettype none

module http_response_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_body_valid,
    output logic [7:0]       m_body_byte,
    output logic [1:0]       m_phase,
    output logic [3:0]       m_error_kind,
    output logic [9:0]       m_status_code,
    output logic [7:0]       m_version_major,
    output logic [7:0]       m_version_minor,
    output logic             m_length_known,
    output logic             m_is_chunked
);

    localparam int LB = hrd_pkg::LenBits;

    typedef enum logic [2:0] {
        PH_STATUS, PH_HEADERS, PH_BODY, PH_CSIZE,
        PH_CDATA, PH_CEND, PH_TRAILER, PH_DONE
    } phase_t;

    // framing flag bits
    localparam int FL_LEN   = 0;
    localparam int FL_CHUNK = 1;
    localparam int FL_CLOSE = 2;
    localparam int FL_BUSY  = 3;
    // number word bits
    localparam int WM_DIG = 0;
    localparam int WM_BAD = 1;
    localparam int WM_OVF = 2;
    // header match bits
    localparam int HM_CL    = 0;
    localparam int HM_TE    = 1;
    localparam int HM_NAME  = 2;
    localparam int HM_TAIL  = 3;
    localparam int HM_COLON = 4;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    localparam logic [LB-1:0] LIM_VER  = LB'(255);
    localparam logic [LB-1:0] LIM_CODE = LB'(999);
    localparam logic [LB-1:0] LIM_LEN  = {LB{1'b1}};

    typedef struct packed {
        logic [LB-1:0] acc;
        logic [2:0]    wm;
    } accum_t;

    function automatic accum_t accum(input logic [LB-1:0] a, input logic [2:0] w,
                                     input logic hex, input logic [3:0] d,
                                     input logic [LB-1:0] lim);
        logic [LB+4:0] wide;
        logic [LB+4:0] prod;
        accum_t        r;
        r.acc = a;
        r.wm  = w;
        wide  = (LB+5)'(a);
        if (!w[WM_OVF]) begin
            prod = hex ? (wide << 4) : ((wide << 3) + (wide << 1));
            prod = prod + (LB+5)'(d);
            if (prod > (LB+5)'(lim)) begin
                r.wm[WM_OVF] = 1'b1;
            end else begin
                r.acc = prod[LB-1:0];
            end
            r.wm[WM_DIG] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [7:0] http_ch(input logic [4:0] p);
        logic [7:0] r;
        unique case (p)
            5'd0:    r = "H";
            5'd1:    r = "T";
            5'd2:    r = "T";
            5'd3:    r = "P";
            5'd4:    r = "/";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] cl_ch(input logic [4:0] p);
        logic [7:0] r;
        unique case (p)
            5'd0:  r = "c";
            5'd1:  r = "o";
            5'd2:  r = "n";
            5'd3:  r = "t";
            5'd4:  r = "e";
            5'd5:  r = "n";
            5'd6:  r = "t";
            5'd7:  r = "-";
            5'd8:  r = "l";
            5'd9:  r = "e";
            5'd10: r = "n";
            5'd11: r = "g";
            5'd12: r = "t";
            5'd13: r = "h";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] te_ch(input logic [4:0] p);
        logic [7:0] r;
        unique case (p)
            5'd0:  r = "t";
            5'd1:  r = "r";
            5'd2:  r = "a";
            5'd3:  r = "n";
            5'd4:  r = "s";
            5'd5:  r = "f";
            5'd6:  r = "e";
            5'd7:  r = "r";
            5'd8:  r = "-";
            5'd9:  r = "e";
            5'd10: r = "n";
            5'd11: r = "c";
            5'd12: r = "o";
            5'd13: r = "d";
            5'd14: r = "i";
            5'd15: r = "n";
            5'd16: r = "g";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] chunked_ch(input logic [2:0] p);
        logic [7:0] r;
        unique case (p)
            3'd0:    r = "c";
            3'd1:    r = "h";
            3'd2:    r = "u";
            3'd3:    r = "n";
            3'd4:    r = "k";
            3'd5:    r = "e";
            3'd6:    r = "d";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 4'(c - "0")};
        end else if (c >= "a" && c <= "f") begin
            r = {1'b1, 4'(c - "a" + 8'd10)};
        end else if (c >= "A" && c <= "F") begin
            r = {1'b1, 4'(c - "A" + 8'd10)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

    function automatic logic [3:0] fail(input logic [3:0] e, input logic [3:0] kind);
        return (e == hrd_pkg::ERR_NONE) ? kind : e;
    endfunction

    // parser state
    phase_t        ph_reg, ph_next;
    logic [4:0]    lp_reg, lp_next;
    logic [4:0]    hm_reg, hm_next;
    logic [2:0]    wm_reg, wm_next;
    logic          pcr_reg, pcr_next;
    logic [LB-1:0] acc_reg, acc_next;
    logic [LB-1:0] dl_reg, dl_next;
    logic [LB-1:0] bl_reg, bl_next;
    logic [9:0]    code_reg, code_next;
    logic [7:0]    major_reg, major_next;
    logic [7:0]    minor_reg, minor_next;
    logic [3:0]    fl_reg, fl_next;
    logic [3:0]    err_reg, err_next;

    // result register
    logic          mv_reg;
    logic          bv_reg, bv_next;
    logic [7:0]    bb_reg, bb_next;

    logic          accept;

    assign s_ready = !mv_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        logic          live;
        logic          pcr0;
        logic          ends;
        logic          act;
        logic [7:0]    b;
        logic [7:0]    ch;
        logic [7:0]    lc;
        logic [4:0]    p;
        logic [4:0]    m;
        logic [4:0]    hv;
        logic          dig;
        logic          blank;
        accum_t        ar;

        ph_next    = ph_reg;
        lp_next    = lp_reg;
        hm_next    = hm_reg;
        wm_next    = wm_reg;
        pcr_next   = pcr_reg;
        acc_next   = acc_reg;
        dl_next    = dl_reg;
        bl_next    = bl_reg;
        code_next  = code_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        fl_next    = fl_reg;
        err_next   = err_reg;
        bv_next    = 1'b0;
        bb_next    = 8'h00;
        b          = s_data_byte;
        pcr0       = 1'b0;
        ends       = 1'b0;
        act        = 1'b0;
        ch         = 8'h00;
        lc         = 8'h00;
        p          = 5'd0;
        m          = 5'd0;
        hv         = 5'd0;
        dig        = 1'b0;
        blank      = 1'b0;
        ar         = '0;
        live       = (err_reg == hrd_pkg::ERR_NONE) && (ph_reg != PH_DONE);

        if (s_req_type == hrd_pkg::REQ_RESTART) begin
            ph_next    = PH_STATUS;
            lp_next    = '0;
            hm_next    = '0;
            wm_next    = '0;
            pcr_next   = 1'b0;
            acc_next   = '0;
            dl_next    = '0;
            bl_next    = '0;
            code_next  = '0;
            major_next = '0;
            minor_next = '0;
            fl_next    = '0;
            err_next   = hrd_pkg::ERR_NONE;
        end else if (s_req_type == hrd_pkg::REQ_CLOSE) begin
            if (live && ph_reg == PH_BODY && fl_reg[FL_CLOSE]) begin
                ph_next = PH_DONE;
            end
        end else if (s_req_type == hrd_pkg::REQ_BYTE && live) begin
            if (ph_reg == PH_BODY || ph_reg == PH_CDATA) begin
                bv_next = 1'b1;
                bb_next = b;
                if (ph_reg == PH_CDATA || !fl_reg[FL_CLOSE]) begin
                    if (bl_reg != '0) begin
                        bl_next = bl_reg - LB'(1);
                    end
                    if (bl_next == '0) begin
                        ph_next = (ph_reg == PH_CDATA) ? PH_CEND : PH_DONE;
                    end
                end
            end else if (ph_reg == PH_CEND) begin
                if (b == CH_LF) begin
                    ph_next  = PH_CSIZE;
                    lp_next  = '0;
                    hm_next  = 5'b00011;
                    wm_next  = '0;
                    acc_next = '0;
                    pcr_next = 1'b0;
                    fl_next[FL_BUSY] = 1'b0;
                end else if (b == CH_CR && !pcr_reg) begin
                    pcr_next = 1'b1;
                end else begin
                    pcr_next = 1'b0;
                    err_next = fail(err_next, hrd_pkg::ERR_CEND);
                end
            end else begin
                // line-oriented phases; a held CR that is not followed by LF
                // is replayed as an ordinary line byte first
                pcr0     = pcr_reg;
                pcr_next = 1'b0;
                ends     = pcr0 && (b == CH_LF);
                for (int k = 0; k < 2; k++) begin
                    ch  = (k == 0) ? CH_CR : b;
                    act = (k == 0) ? (pcr0 && b != CH_LF)
                                   : (!ends && err_next == hrd_pkg::ERR_NONE &&
                                      b != CH_CR && b != CH_LF);
                    lc    = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
                    dig   = (ch >= "0" && ch <= "9");
                    blank = (ch == CH_SP) || (ch == CH_TAB);
                    p     = lp_next;
                    if (act) begin
                        priority case (ph_next)
                            PH_STATUS: begin
                                if (p < 5'd5) begin
                                    if (ch != http_ch(p)) begin
                                        err_next = fail(err_next, hrd_pkg::ERR_NO_HTTP);
                                    end else begin
                                        lp_next = p + 5'd1;
                                    end
                                end else if (p == 5'd5 || p == 5'd6) begin
                                    if (ch == CH_SP) begin
                                        if (p == 5'd5 || wm_next[WM_BAD] ||
                                            !wm_next[WM_DIG]) begin
                                            err_next = fail(err_next, hrd_pkg::ERR_VERSION);
                                        end else if (wm_next[WM_OVF]) begin
                                            err_next = fail(err_next, hrd_pkg::ERR_OVERFLOW);
                                        end else begin
                                            major_next = dl_next[7:0];
                                            minor_next = acc_next[7:0];
                                            dl_next    = '0;
                                            acc_next   = '0;
                                            wm_next    = '0;
                                            lp_next    = 5'd7;
                                        end
                                    end else if (p == 5'd5 && ch == CH_DOT) begin
                                        if (!wm_next[WM_DIG]) begin
                                            wm_next[WM_BAD] = 1'b1;
                                        end
                                        dl_next = acc_next;
                                        acc_next = '0;
                                        wm_next[WM_DIG] = 1'b0;
                                        lp_next = 5'd6;
                                    end else if (dig) begin
                                        ar = accum(acc_next, wm_next, 1'b0, 4'(ch - "0"),
                                                   LIM_VER);
                                        acc_next = ar.acc;
                                        wm_next  = ar.wm;
                                    end else begin
                                        wm_next[WM_BAD] = 1'b1;
                                    end
                                end else if (p == 5'd7) begin
                                    if (dig) begin
                                        ar = accum(acc_next, wm_next, 1'b0, 4'(ch - "0"),
                                                   LIM_CODE);
                                        acc_next = ar.acc;
                                        wm_next  = ar.wm;
                                        lp_next  = 5'd8;
                                    end else if (!blank) begin
                                        err_next = fail(err_next, hrd_pkg::ERR_CODE);
                                    end
                                end else if (p == 5'd8) begin
                                    if (dig) begin
                                        ar = accum(acc_next, wm_next, 1'b0, 4'(ch - "0"),
                                                   LIM_CODE);
                                        acc_next = ar.acc;
                                        wm_next  = ar.wm;
                                    end else if (ch == CH_SP) begin
                                        if (wm_next[WM_OVF]) begin
                                            err_next = fail(err_next, hrd_pkg::ERR_OVERFLOW);
                                        end else begin
                                            code_next = acc_next[9:0];
                                        end
                                        lp_next = 5'd10;
                                    end else if (ch == CH_TAB) begin
                                        lp_next = 5'd9;
                                    end else begin
                                        err_next = fail(err_next, hrd_pkg::ERR_CODE);
                                    end
                                end else if (p == 5'd9) begin
                                    if (!blank) begin
                                        err_next = fail(err_next, hrd_pkg::ERR_CODE);
                                    end
                                end
                            end
                            PH_HEADERS: begin
                                fl_next[FL_BUSY] = 1'b1;
                                if (!hm_next[HM_COLON]) begin
                                    if (ch == CH_COLON) begin
                                        if (!hm_next[HM_NAME]) begin
                                            err_next = fail(err_next, hrd_pkg::ERR_EMPTY_HDR);
                                        end else begin
                                            m = 5'd0;
                                            m[HM_COLON] = 1'b1;
                                            m[HM_CL] = hm_next[HM_CL] && (p == 5'd14);
                                            m[HM_TE] = hm_next[HM_TE] && (p == 5'd17);
                                            hm_next  = m;
                                            wm_next  = '0;
                                            acc_next = '0;
                                        end
                                    end else if (blank) begin
                                        if (hm_next[HM_NAME]) begin
                                            hm_next[HM_TAIL] = 1'b1;
                                        end
                                    end else if (hm_next[HM_TAIL]) begin
                                        hm_next[HM_CL] = 1'b0;
                                        hm_next[HM_TE] = 1'b0;
                                    end else begin
                                        if (p >= 5'd14 || lc != cl_ch(p)) begin
                                            hm_next[HM_CL] = 1'b0;
                                        end
                                        if (p >= 5'd17 || lc != te_ch(p)) begin
                                            hm_next[HM_TE] = 1'b0;
                                        end
                                        if (p < 5'd31) begin
                                            lp_next = p + 5'd1;
                                        end
                                        hm_next[HM_NAME] = 1'b1;
                                    end
                                end else if (hm_next[HM_CL]) begin
                                    if (blank) begin
                                        if (wm_next[WM_DIG]) begin
                                            wm_next[WM_BAD] = 1'b1;
                                        end
                                    end else if (dig && !wm_next[WM_BAD]) begin
                                        ar = accum(acc_next, wm_next, 1'b0, 4'(ch - "0"),
                                                   LIM_LEN);
                                        acc_next = ar.acc;
                                        wm_next  = ar.wm;
                                    end else begin
                                        err_next = fail(err_next, hrd_pkg::ERR_LENGTH);
                                    end
                                end else if (hm_next[HM_TE]) begin
                                    // running match for "chunked" in the value
                                    if (wm_next < 3'd7) begin
                                        if (lc == chunked_ch(wm_next)) begin
                                            wm_next = wm_next + 3'd1;
                                        end else begin
                                            wm_next = (lc == "c") ? 3'd1 : 3'd0;
                                        end
                                    end
                                end
                            end
                            PH_CSIZE: begin
                                hv = hex_val(ch);
                                if (!p[0]) begin
                                    if (ch == CH_SEMI) begin
                                        if (!wm_next[WM_DIG]) begin
                                            err_next = fail(err_next, hrd_pkg::ERR_CSIZE);
                                        end else begin
                                            lp_next = 5'd1;
                                        end
                                    end else if (blank) begin
                                        if (wm_next[WM_DIG]) begin
                                            wm_next[WM_BAD] = 1'b1;
                                        end
                                    end else if (hv[4] && !wm_next[WM_BAD]) begin
                                        ar = accum(acc_next, wm_next, 1'b1, hv[3:0], LIM_LEN);
                                        acc_next = ar.acc;
                                        wm_next  = ar.wm;
                                    end else begin
                                        err_next = fail(err_next, hrd_pkg::ERR_CSIZE);
                                    end
                                end
                            end
                            default: begin
                                fl_next[FL_BUSY] = 1'b1;
                            end
                        endcase
                    end
                end
                if (!ends && err_next == hrd_pkg::ERR_NONE) begin
                    if (b == CH_CR) begin
                        pcr_next = 1'b1;
                    end else if (b == CH_LF) begin
                        ends = 1'b1;
                    end
                end
                if (ends) begin
                    pcr_next = 1'b0;
                    priority case (ph_next)
                        PH_STATUS: begin
                            p = lp_next;
                            if (p < 5'd5) begin
                                err_next = fail(err_next, hrd_pkg::ERR_NO_HTTP);
                            end else if (p < 5'd7) begin
                                err_next = fail(err_next, hrd_pkg::ERR_NO_SPACE);
                            end else if (p == 5'd7) begin
                                err_next = fail(err_next, hrd_pkg::ERR_CODE);
                            end else if (p < 5'd10) begin
                                if (wm_next[WM_OVF]) begin
                                    err_next = fail(err_next, hrd_pkg::ERR_OVERFLOW);
                                end else begin
                                    code_next = acc_next[9:0];
                                end
                            end
                            if (err_next == hrd_pkg::ERR_NONE) begin
                                ph_next  = PH_HEADERS;
                                lp_next  = '0;
                                hm_next  = 5'b00011;
                                wm_next  = '0;
                                acc_next = '0;
                                fl_next[FL_BUSY] = 1'b0;
                            end
                        end
                        PH_HEADERS: begin
                            if (!fl_next[FL_BUSY]) begin
                                // blank line ends the header block
                                if (fl_next[FL_CHUNK]) begin
                                    ph_next = PH_CSIZE;
                                end else if (fl_next[FL_LEN]) begin
                                    bl_next = dl_next;
                                    ph_next = (dl_next == '0) ? PH_DONE : PH_BODY;
                                end else begin
                                    fl_next[FL_CLOSE] = 1'b1;
                                    ph_next = PH_BODY;
                                end
                            end else if (!hm_next[HM_COLON]) begin
                                err_next = fail(err_next, hrd_pkg::ERR_NO_COLON);
                            end else if (hm_next[HM_CL]) begin
                                if (!wm_next[WM_DIG]) begin
                                    err_next = fail(err_next, hrd_pkg::ERR_LENGTH);
                                end else if (wm_next[WM_OVF]) begin
                                    err_next = fail(err_next, hrd_pkg::ERR_OVERFLOW);
                                end else begin
                                    dl_next = acc_next;
                                    fl_next[FL_LEN] = 1'b1;
                                end
                            end else if (hm_next[HM_TE] && wm_next == 3'd7) begin
                                fl_next[FL_CHUNK] = 1'b1;
                            end
                            lp_next  = '0;
                            hm_next  = 5'b00011;
                            wm_next  = '0;
                            acc_next = '0;
                            fl_next[FL_BUSY] = 1'b0;
                        end
                        PH_CSIZE: begin
                            if (!wm_next[WM_DIG]) begin
                                err_next = fail(err_next, hrd_pkg::ERR_CSIZE);
                            end else if (wm_next[WM_OVF]) begin
                                err_next = fail(err_next, hrd_pkg::ERR_OVERFLOW);
                            end else begin
                                if (acc_next == '0) begin
                                    ph_next = PH_TRAILER;
                                end else begin
                                    bl_next = acc_next;
                                    ph_next = PH_CDATA;
                                end
                                lp_next  = '0;
                                hm_next  = 5'b00011;
                                wm_next  = '0;
                                acc_next = '0;
                                fl_next[FL_BUSY] = 1'b0;
                            end
                        end
                        default: begin
                            // trailer: an empty line closes the response
                            if (!fl_next[FL_BUSY]) begin
                                ph_next = PH_DONE;
                            end else begin
                                lp_next  = '0;
                                hm_next  = 5'b00011;
                                wm_next  = '0;
                                acc_next = '0;
                                fl_next[FL_BUSY] = 1'b0;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg    <= PH_STATUS;
            lp_reg    <= '0;
            hm_reg    <= '0;
            wm_reg    <= '0;
            pcr_reg   <= 1'b0;
            acc_reg   <= '0;
            dl_reg    <= '0;
            bl_reg    <= '0;
            code_reg  <= '0;
            major_reg <= '0;
            minor_reg <= '0;
            fl_reg    <= '0;
            err_reg   <= hrd_pkg::ERR_NONE;
            mv_reg    <= 1'b0;
        end else begin
            if (accept) begin
                ph_reg    <= ph_next;
                lp_reg    <= lp_next;
                hm_reg    <= hm_next;
                wm_reg    <= wm_next;
                pcr_reg   <= pcr_next;
                acc_reg   <= acc_next;
                dl_reg    <= dl_next;
                bl_reg    <= bl_next;
                code_reg  <= code_next;
                major_reg <= major_next;
                minor_reg <= minor_next;
                fl_reg    <= fl_next;
                err_reg   <= err_next;
                mv_reg    <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            bv_reg <= bv_next;
            bb_reg <= bb_next;
        end
    end

    assign m_valid         = mv_reg;
    assign m_body_valid    = bv_reg;
    assign m_body_byte     = bb_reg;
    assign m_phase         = (err_reg != hrd_pkg::ERR_NONE) ? hrd_pkg::OUT_ERROR :
                             (ph_reg == PH_DONE) ? hrd_pkg::OUT_DONE : hrd_pkg::OUT_BUSY;
    assign m_error_kind    = err_reg;
    assign m_status_code   = code_reg;
    assign m_version_major = major_reg;
    assign m_version_minor = minor_reg;
    assign m_length_known  = fl_reg[FL_LEN];
    assign m_is_chunked    = fl_reg[FL_CHUNK];

endmodule

`default_nettype wire

@@ rtl/core/hrd_checker.sv @@
// ----------------------------------------------------------------------------
// hrd_checker
// Port-level checks for the HTTP response deframer.
// ----------------------------------------------------------------------------
`default_nettype none

module hrd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [1:0]  s_req_type,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_body_valid,
    input wire logic [7:0]  m_body_byte,
    input wire logic [1:0]  m_phase,
    input wire logic [3:0]  m_error_kind,
    input wire logic [9:0]  m_status_code
);

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_body_byte) && $stable(m_phase))
        else $error("result beat changed while stalled");

    // error phase and error code agree
    a_err_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_phase == hrd_pkg::OUT_ERROR) == (m_error_kind != hrd_pkg::ERR_NONE)))
        else $error("phase and error kind disagree");

    // non-body beats carry a zero byte
    a_body_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_body_valid |-> m_body_byte == 8'h00)
        else $error("body byte set without body_valid");

    // a restart beat yields a clean result in the next cycle
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req_type == hrd_pkg::REQ_RESTART |=>
            m_valid && m_phase == hrd_pkg::OUT_BUSY && m_status_code == 10'd0 &&
            !m_body_valid)
        else $error("restart did not clear the parser");

endmodule

bind http_response_deframer hrd_checker u_hrd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_req_type    (s_req_type),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_body_valid  (m_body_valid),
    .m_body_byte   (m_body_byte),
    .m_phase       (m_phase),
    .m_error_kind  (m_error_kind),
    .m_status_code (m_status_code)
);

`default_nettype wire
